// ===== hdl/sctu_pkg.sv =====
// sctu_pkg: shared types and constants for the sine/cosine Taylor series unit.
// No dependencies.
package sctu_pkg;

   // pi and 2*pi at 60 fraction bits, rounded to nearest in the working format at elaboration
   localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;
   localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;

   // datapath widths
   localparam int X_W    = 32;  // x squared, unsigned
   localparam int TERM_W = 34;  // series term and running sum, signed
   localparam int MAG_W  = 35;  // magnitude of term * x2 after the shift
   localparam int DIV_W  = 11;  // largest divisor is 38 * 39
   localparam int QR_W   = 16;  // quotient of angle by 2*pi

   typedef enum logic {
      OP_SINE   = 1'b0,
      OP_COSINE = 1'b1
   } op_type;

   typedef struct packed {
      op_type                     op;
      logic [X_W-1:0]             x2;
      logic signed [TERM_W-1:0]   term;
      logic signed [TERM_W-1:0]   sum;
   } beat_type;

   // divisor of series step idx: (2i)(2i+1) for sine, (2i-1)(2i) for cosine
   function automatic logic [DIV_W-1:0] term_divisor(input int idx, input op_type op);
      int d;
      if (op == OP_COSINE) begin
         d = (2 * idx - 1) * (2 * idx);
      end else begin
         d = (2 * idx) * (2 * idx + 1);
      end
      return DIV_W'(d);
   endfunction

endpackage

// ===== hdl/sine_cosine_taylor_unit.sv =====
// sine_cosine_taylor_unit: top level, angle reduction followed by a chain of series steps.
// Depends on sctu_pkg, sctu_reduce and sctu_term.
//
// Usage:
//   Request channel (req_valid / req_stall) carries a signed angle in radians with
//   FRACTION_BITS fraction bits and an operation bit (0 sine, 1 cosine). Response
//   channel (rsp_valid / rsp_stall) returns one beat per request, in order, holding
//   the sine or cosine in the same fixed-point format.
//   Each beat passes through the angle folding and squaring stages, then through
//   the stages of each series step (multiply, magnitude, reciprocal multiply,
//   divisor multiply, correct and accumulate).
//   Throughput is one beat per cycle while not stalled; every stage is pipelined.
//   While a response beat waits under rsp_stall the whole pipeline holds and
//   req_stall is raised, so nothing is dropped or repeated.
//   Reset clears all valid bits; the block keeps no state between beats.
module sine_cosine_taylor_unit #(
   parameter int TERM_COUNT    = 19,
   parameter int FRACTION_BITS = 28
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [31:0]  req_angle,
   input  logic                req_operation,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_value
);

   logic               enable;
   logic               valid_w [0:TERM_COUNT];
   sctu_pkg::beat_type beat_w  [0:TERM_COUNT];

   // global hold while the output beat is stalled
   assign enable    = !(rsp_valid && rsp_stall);
   assign req_stall = !enable;

   sctu_reduce #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_reduce (
      .clock        (clock),
      .reset        (reset),
      .enable       (enable),
      .in_valid     (req_valid),
      .in_angle     (req_angle),
      .in_operation (req_operation),
      .out_valid    (valid_w[0]),
      .out_beat     (beat_w[0])
   );

   // one pipelined step per series term
   for (genvar g = 1; g <= TERM_COUNT; g++) begin : g_term
      sctu_term #(
         .FRACTION_BITS(FRACTION_BITS),
         .IDX          (g)
      ) u_term (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .in_valid  (valid_w[g-1]),
         .in_beat   (beat_w[g-1]),
         .out_valid (valid_w[g]),
         .out_beat  (beat_w[g])
      );
   end

   assign rsp_valid = valid_w[TERM_COUNT];
   assign rsp_value = beat_w[TERM_COUNT].sum[31:0];

endmodule

// ===== hdl/sctu_reduce.sv =====
// sctu_reduce: folds the angle into [-pi, pi], squares it and seeds the series.
// Depends on sctu_pkg.
module sctu_reduce #(
   parameter int FRACTION_BITS = 28
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  logic                 in_valid,
   input  logic signed [31:0]   in_angle,
   input  logic                 in_operation,
   output logic                 out_valid,
   output sctu_pkg::beat_type   out_beat
);

   localparam int          F         = FRACTION_BITS;
   localparam logic [63:0] PI_FULL   = (sctu_pkg::PI_Q60 + (64'd1 << (59 - F))) >> (60 - F);
   localparam logic [63:0] TWO_FULL  = (sctu_pkg::TWO_PI_Q60 + (64'd1 << (59 - F))) >> (60 - F);
   localparam logic [31:0] PI_C      = PI_FULL[31:0];
   localparam logic [31:0] TWO_C     = TWO_FULL[31:0];
   localparam int          RSH       = F + 35;
   localparam logic [63:0] RECIP_FULL = (64'd1 << RSH) / TWO_FULL;
   localparam logic [33:0] RECIP     = RECIP_FULL[33:0];
   localparam logic [31:0] ONE       = 32'd1 << F;

   logic                  v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic                  neg1_ff, neg2_ff, neg3_ff;
   sctu_pkg::op_type      op1_ff, op2_ff, op3_ff, op4_ff, op5_ff;
   logic [31:0]           mag1_ff, mag2_ff, mag3_ff;
   logic [31:0]           mag1_in;
   logic [65:0]           rprod, rquot;
   logic [sctu_pkg::QR_W-1:0] q2_ff, q2_in;
   logic [47:0]           qt3_ff, qt3_in;
   logic [47:0]           r_a, r_b;
   logic signed [32:0]    x4_ff, x4_in;
   logic signed [32:0]    pi_s, two_s, x_fold;
   logic signed [31:0]    x5_ff, x5_in;
   logic signed [63:0]    sq;
   logic [63:0]           sq_sh;
   sctu_pkg::beat_type    beat6_ff, beat6_in;

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   // stage 1: sign and magnitude
   assign mag1_in = in_angle[31] ? 32'(-in_angle) : 32'(in_angle);

   // stage 2: quotient estimate by reciprocal, may be one low
   assign rprod = 66'(mag1_ff) * 66'(RECIP);
   assign rquot = rprod >> RSH;
   assign q2_in = rquot[sctu_pkg::QR_W-1:0];

   // stage 3: quotient times 2*pi
   assign qt3_in = 48'(q2_ff) * 48'(TWO_C);

   // stage 4: remainder with one correction, sign restored
   always_comb begin
      r_a = 48'(mag3_ff) - qt3_ff;
      r_b = (r_a >= 48'(TWO_C)) ? r_a - 48'(TWO_C) : r_a;
      x4_in = neg3_ff ? -$signed({2'b00, r_b[30:0]}) : $signed({2'b00, r_b[30:0]});
   end

   // stage 5: fold into [-pi, pi]
   always_comb begin
      pi_s  = $signed({1'b0, PI_C});
      two_s = $signed({1'b0, TWO_C});
      if (x4_ff > pi_s) begin
         x_fold = x4_ff - two_s;
      end else if (x4_ff < -pi_s) begin
         x_fold = x4_ff + two_s;
      end else begin
         x_fold = x4_ff;
      end
      x5_in = 32'(x_fold);
   end

   // stage 6: square and series seed
   always_comb begin
      sq    = 64'(x5_ff) * 64'(x5_ff);
      sq_sh = 64'(sq) >> F;
      beat6_in.op = op5_ff;
      beat6_in.x2 = sq_sh[sctu_pkg::X_W-1:0];
      if (op5_ff == sctu_pkg::OP_COSINE) begin
         beat6_in.term = $signed({2'b00, ONE});
      end else begin
         beat6_in.term = sctu_pkg::TERM_W'(x5_ff);
      end
      beat6_in.sum = beat6_in.term;
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (enable) begin
         neg1_ff  <= in_angle[31];
         mag1_ff  <= mag1_in;
         op1_ff   <= sctu_pkg::op_type'(in_operation);
         neg2_ff  <= neg1_ff;
         mag2_ff  <= mag1_ff;
         op2_ff   <= op1_ff;
         q2_ff    <= q2_in;
         neg3_ff  <= neg2_ff;
         mag3_ff  <= mag2_ff;
         op3_ff   <= op2_ff;
         qt3_ff   <= qt3_in;
         x4_ff    <= x4_in;
         op4_ff   <= op3_ff;
         x5_ff    <= x5_in;
         op5_ff   <= op4_ff;
         beat6_ff <= beat6_in;
      end
   end

   assign out_valid = v6_ff;
   assign out_beat  = beat6_ff;

endmodule

// ===== hdl/sctu_term.sv =====
// sctu_term: one Taylor series step, term = -(term * x2 >> F) / divisor, added to the sum.
// Depends on sctu_pkg.
module sctu_term #(
   parameter int FRACTION_BITS = 28,
   parameter int IDX           = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  logic                 in_valid,
   input  sctu_pkg::beat_type   in_beat,
   output logic                 out_valid,
   output sctu_pkg::beat_type   out_beat
);

   localparam int MW = sctu_pkg::MAG_W;
   localparam int PW = sctu_pkg::TERM_W + sctu_pkg::X_W + 1;
   localparam logic [sctu_pkg::DIV_W-1:0] DS = sctu_pkg::term_divisor(IDX, sctu_pkg::OP_SINE);
   localparam logic [sctu_pkg::DIV_W-1:0] DC = sctu_pkg::term_divisor(IDX, sctu_pkg::OP_COSINE);
   localparam logic [63:0] MS_FULL = (64'd1 << MW) / 64'(DS);
   localparam logic [63:0] MC_FULL = (64'd1 << MW) / 64'(DC);
   localparam logic [MW-1:0] MS = MS_FULL[MW-1:0];
   localparam logic [MW-1:0] MC = MC_FULL[MW-1:0];

   logic                    va_ff, vb_ff, vc_ff, vd_ff, ve_ff;
   sctu_pkg::beat_type      ba_ff, bb_ff, bc_ff, bd_ff, be_ff, be_in;
   logic signed [PW-1:0]    pa_ff, pa_in, sh;
   logic [PW-1:0]           mag;
   logic                    negb_ff, negc_ff, negd_ff;
   logic [MW-1:0]           mb_ff, mc_ff, md_ff;
   logic [MW-1:0]           recip_c, qc_in, qc_ff, qd_q_ff;
   logic [2*MW-1:0]         qprod, qsh;
   logic [sctu_pkg::DIV_W-1:0] div_d;
   logic [MW+sctu_pkg::DIV_W-1:0] qd_ff, qd_in, rem;
   logic [MW-1:0]           q_fix;
   logic signed [sctu_pkg::TERM_W-1:0] t_new;

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
      end else if (enable) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
         ve_ff <= vd_ff;
      end
   end

   // stage a: term * x2
   assign pa_in = PW'(in_beat.term) * $signed({1'b0, in_beat.x2});

   // stage b: floor shift, then magnitude
   assign sh  = pa_ff >>> FRACTION_BITS;
   assign mag = sh[PW-1] ? PW'(-sh) : PW'(sh);

   // stage c: quotient estimate by reciprocal, may be one low
   always_comb begin
      recip_c = (bb_ff.op == sctu_pkg::OP_COSINE) ? MC : MS;
      qprod   = (2*MW)'(mb_ff) * (2*MW)'(recip_c);
      qsh     = qprod >> MW;
      qc_in   = qsh[MW-1:0];
   end

   // stage d: estimate times divisor
   always_comb begin
      div_d = (bc_ff.op == sctu_pkg::OP_COSINE) ? DC : DS;
      qd_in = (MW+sctu_pkg::DIV_W)'(qc_ff) * (MW+sctu_pkg::DIV_W)'(div_d);
   end

   // stage e: correct quotient, negate, accumulate
   always_comb begin
      rem   = (MW+sctu_pkg::DIV_W)'(md_ff) - qd_ff;
      q_fix = qd_q_ff;
      if (bd_ff.op == sctu_pkg::OP_COSINE) begin
         if (rem >= (MW+sctu_pkg::DIV_W)'(DC)) q_fix = qd_q_ff + MW'(1);
      end else begin
         if (rem >= (MW+sctu_pkg::DIV_W)'(DS)) q_fix = qd_q_ff + MW'(1);
      end
      t_new = negd_ff ? $signed(sctu_pkg::TERM_W'(q_fix)) : -$signed(sctu_pkg::TERM_W'(q_fix));
      be_in      = bd_ff;
      be_in.term = t_new;
      be_in.sum  = bd_ff.sum + t_new;
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (enable) begin
         ba_ff   <= in_beat;
         pa_ff   <= pa_in;
         bb_ff   <= ba_ff;
         negb_ff <= sh[PW-1];
         mb_ff   <= mag[MW-1:0];
         bc_ff   <= bb_ff;
         negc_ff <= negb_ff;
         mc_ff   <= mb_ff;
         qc_ff   <= qc_in;
         bd_ff   <= bc_ff;
         negd_ff <= negc_ff;
         md_ff   <= mc_ff;
         qd_q_ff <= qc_ff;
         qd_ff   <= qd_in;
         be_ff   <= be_in;
      end
   end

   assign out_valid = ve_ff;
   assign out_beat  = be_ff;

endmodule
